FILE: src/dce_pkg.sv
package dce_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 17;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG = 1'd1;

	localparam logic [16:0] GAIN_RESET = 17'd4096;
	localparam logic [15:0] SEG_RESET = 16'd1448;

	localparam logic [16:0] Q16_ONE = 17'h10000;
	localparam logic [17:0] Q17_TWO = 18'h20000;

	// item op codes
	localparam logic OP_ACK = 1'b0;
	localparam logic OP_LOSS = 1'b1;

	// command queue between front and back
	localparam int unsigned CMD_DEPTH = 2;

	typedef struct packed {
		logic        op;
		logic [15:0] segments_acked;
		logic        ece_received;
		logic [31:0] last_acked_seq;
		logic [31:0] next_tx_seq;
		logic [31:0] cwnd_bytes;
	} item_t;

	typedef struct packed {
		logic [16:0] alpha_q16;
		logic        window_closed;
		logic [31:0] ssthresh_bytes;
	} result_t;

	typedef struct packed {
		logic        is_loss;
		logic        ece;
		logic [31:0] bytes;
		logic [31:0] acked_seq;
		logic [31:0] next_seq;
		logic [31:0] cwnd;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage

FILE: src/dce_fifo.sv
module dce_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: src/dce_front.sv
module dce_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  dce_pkg::item_t                  item,
	input  logic                            cfg_we,
	input  logic [dce_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dce_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dce_pkg::qctl_t                  qctl,
	input  logic                            q_full,
	output dce_pkg::cmd_t                   cmd,
	output logic [16:0]                     gain
);

	logic [16:0] gain_q;
	logic [15:0] seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= dce_pkg::GAIN_RESET;
			seg_q <= dce_pkg::SEG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				dce_pkg::REG_GAIN: gain_q <= cfg_data;
				dce_pkg::REG_SEG:  seg_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// gain above one acts as one
	assign gain = (gain_q > dce_pkg::Q16_ONE) ? dce_pkg::Q16_ONE : gain_q;

	// 16x16 product always fits 32 bits
	always_comb begin
		cmd.is_loss = (item.op == dce_pkg::OP_LOSS);
		cmd.ece = item.ece_received;
		cmd.bytes = 32'(item.segments_acked) * 32'(seg_q);
		cmd.acked_seq = item.last_acked_seq;
		cmd.next_seq = item.next_tx_seq;
		cmd.cwnd = item.cwnd_bytes;
	end

	assign qctl.full = q_full;
	assign qctl.push = push && !q_full;

endmodule

FILE: src/dce_back.sv
module dce_back #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  dce_pkg::cmd_t    q_cmd,
	output logic             q_pop,
	input  logic [16:0]      gain,
	input  logic             pop,
	output dce_pkg::result_t res,
	output logic             res_valid
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_LMUL = 3'd5;
	localparam logic [2:0] ST_LOUT = 3'd6;

	localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
	localparam int unsigned SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int unsigned SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

	logic [2:0]           state_q;
	logic [16:0]          alpha_q;
	logic [31:0]          tot_q;
	logic [31:0]          mk_q;
	logic [31:0]          wend_q;
	logic                 wend_valid_q;
	logic                 res_valid_q;

	dce_pkg::cmd_t        cmd_q;
	dce_pkg::result_t     res_q;
	logic [32:0]          rem_q;
	logic [31:0]          dvs_q;
	logic [FRAC_BITS:0]   quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [33:0]          p1_q;
	logic [33:0]          p2_q;
	logic [49:0]          lprod_q;

	logic [32:0]          tot_sum;
	logic [32:0]          mk_sum;
	logic [31:0]          tot_n;
	logic [31:0]          mk_n;
	logic [31:0]          wend;
	logic [31:0]          seq_diff;
	logic                 closed;
	logic                 ge;
	logic [32:0]          diff;
	logic [FRAC_BITS:0]   quo_cl;
	logic [FRAC_BITS+16:0] f_wide;
	logic [16:0]          f16;
	logic [34:0]          acc;
	logic [17:0]          alpha_sum;
	logic [16:0]          alpha_new;
	logic [17:0]          loss_fac;
	logic                 start;
	logic                 div_last;

	assign start = (state_q == ST_IDLE) && !q_empty && !res_valid_q;
	assign q_pop = start;
	assign res = res_q;
	assign res_valid = res_valid_q;

	always_comb begin
		tot_sum = {1'b0, tot_q} + {1'b0, cmd_q.bytes};
		mk_sum = {1'b0, mk_q} + {1'b0, cmd_q.bytes};
		tot_n = tot_sum[32] ? '1 : tot_sum[31:0];
		mk_n = cmd_q.ece ? (mk_sum[32] ? '1 : mk_sum[31:0]) : mk_q;
		wend = wend_valid_q ? wend_q : cmd_q.next_seq;
		seq_diff = cmd_q.acked_seq - wend;
		closed = !seq_diff[31];
		// one restoring step a cycle
		ge = (rem_q >= {1'b0, dvs_q});
		diff = ge ? rem_q - {1'b0, dvs_q} : rem_q;
		div_last = (cnt_q == CNT_W'(FRAC_BITS));
		quo_cl = (quo_q > ONE_F) ? ONE_F : quo_q;
		f_wide = ({16'd0, quo_cl} << SHL) >> SHR;
		f16 = f_wide[16:0];
		acc = {1'b0, p1_q} + {1'b0, p2_q};
		alpha_sum = acc[33:16];
		alpha_new = (alpha_sum > {1'b0, dce_pkg::Q16_ONE}) ? dce_pkg::Q16_ONE
		                                                   : alpha_sum[16:0];
		loss_fac = dce_pkg::Q17_TWO - {1'b0, alpha_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			alpha_q <= dce_pkg::Q16_ONE;
			tot_q <= '0;
			mk_q <= '0;
			wend_q <= '0;
			wend_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= q_cmd.is_loss ? ST_LMUL : ST_ACK;
					end
				end
				ST_ACK: begin
					wend_valid_q <= 1'b1;
					if (closed) begin
						wend_q <= cmd_q.next_seq;
						tot_q <= '0;
						mk_q <= '0;
						state_q <= (tot_n == '0) ? ST_MUL : ST_DIV;
					end else begin
						wend_q <= wend;
						tot_q <= tot_n;
						mk_q <= mk_n;
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					alpha_q <= alpha_new;
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LMUL: begin
					state_q <= ST_LOUT;
				end
				ST_LOUT: begin
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= q_cmd;
				end
			end
			ST_ACK: begin
				dvs_q <= tot_n;
				rem_q <= {1'b0, mk_n};
				quo_q <= '0;
				cnt_q <= '0;
				res_q.alpha_q16 <= alpha_q;
				res_q.window_closed <= 1'b0;
				res_q.ssthresh_bytes <= '0;
			end
			ST_DIV: begin
				quo_q <= {quo_q[FRAC_BITS-1:0], ge};
				rem_q <= {diff[31:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_MUL: begin
				p1_q <= 34'(alpha_q) * 34'(dce_pkg::Q16_ONE - gain);
				p2_q <= 34'(f16) * 34'(gain);
			end
			ST_SUM: begin
				res_q.alpha_q16 <= alpha_new;
				res_q.window_closed <= 1'b1;
				res_q.ssthresh_bytes <= '0;
			end
			ST_LMUL: begin
				lprod_q <= 50'(cmd_q.cwnd) * 50'(loss_fac);
			end
			ST_LOUT: begin
				res_q.alpha_q16 <= alpha_q;
				res_q.window_closed <= 1'b0;
				res_q.ssthresh_bytes <= lprod_q[48:17];
			end
			default: ;
		endcase
	end

endmodule

FILE: src/dctcp_congestion_estimator_top.sv
// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------------
// item in   | push / full        | item   (op, segments, echo, seqs, cwnd)
// result    | pop / empty        | result (alpha, window closed, ssthresh)
// config    | cfg_we             | cfg_idx, cfg_data (0 = gain, 1 = seg bytes)
//
// Steps below run from the accepting push to the result waiting on pop.
// Ack that leaves the window open: queue, command load, counters.
// Ack that closes the window: queue, command load, window check, then the divider,
// which retires one quotient bit a cycle (FRAC_BITS + 1 bits) on marked/total.
// Loss query: queue, command load, one 32x18 multiply, then the output register.
// Reset clears state at once (alpha 1.0, counters 0); no clearing pass.
// A two-item command queue keeps push going while a result waits on pop.
module dctcp_congestion_estimator_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  dce_pkg::item_t                 item,
	input  logic                           pop,
	output logic                           empty,
	output dce_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [dce_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dce_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned CMD_W = $bits(dce_pkg::cmd_t);

	dce_pkg::qctl_t   qctl;
	dce_pkg::cmd_t    front_cmd;
	dce_pkg::cmd_t    back_cmd;
	logic [CMD_W-1:0] back_cmd_bits;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [16:0]      gain;
	logic             res_valid;

	// front end: config registers, op decode and the byte count product
	dce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.qctl     (qctl),
		.q_full   (q_full),
		.cmd      (front_cmd),
		.gain     (gain)
	);

	assign full = qctl.full;

	// decoupling queue between front and back
	dce_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (dce_pkg::CMD_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (qctl.push),
		.wr_data (front_cmd),
		.rd_en   (q_pop),
		.rd_data (back_cmd_bits),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign back_cmd = dce_pkg::cmd_t'(back_cmd_bits);

	// back end: counters, window tracking, divider, alpha update, ssthresh
	dce_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (back_cmd),
		.q_pop     (q_pop),
		.gain      (gain),
		.pop       (pop),
		.res       (result),
		.res_valid (res_valid)
	);

	assign empty = !res_valid;

endmodule

FILE: src/dce_checker.sv
module dce_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pop,
	input logic             empty,
	input dce_pkg::result_t result
);

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	// alpha never above one
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.alpha_q16 <= dce_pkg::Q16_ONE))
		else $error("alpha above one");

	// a window close comes from an ack, which carries no threshold
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.window_closed && (result.ssthresh_bytes != '0)))
		else $error("ack result with a threshold");

endmodule

bind dctcp_congestion_estimator_top dce_checker u_chk (.*);

FILE: tb/dctcp_congestion_estimator_checker.sv
`timescale 1ns / 100ps

module dctcp_congestion_estimator_checker #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  dce_pkg::item_t                 item,
	input  logic                           pop,
	input  logic                           empty,
	input  dce_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [dce_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dce_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding
);

	logic [16:0] gain;
	logic [15:0] seg_bytes;
	logic [16:0] alpha;
	logic [31:0] bytes_total;
	logic [31:0] bytes_marked;
	logic [31:0] win_end;
	logic        win_valid;

	dce_pkg::result_t awaited_results[$];

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = {32'd0, a} + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// advances the estimator copy by one item, returns what the block should give back
	function automatic dce_pkg::result_t estimate(input dce_pkg::item_t it);
		dce_pkg::result_t r;
		logic [63:0]      bytes;
		logic [63:0]      frac;
		logic [63:0]      acc;
		logic [63:0]      one;
		logic [31:0]      gap;
		logic [16:0]      g;
		r = '0;
		if (it.op == dce_pkg::OP_LOSS) begin
			acc = 64'(it.cwnd_bytes) * (64'(dce_pkg::Q17_TWO) - 64'(alpha));
			acc = acc >> 17;
			r.ssthresh_bytes = acc[31:0];
		end else begin
			bytes = 64'(it.segments_acked) * 64'(seg_bytes);
			bytes_total = sat_add32(bytes_total, bytes);
			if (it.ece_received)
				bytes_marked = sat_add32(bytes_marked, bytes);
			if (!win_valid) begin
				win_end = it.next_tx_seq;
				win_valid = 1'b1;
			end
			// serial compare: acked at or past window end
			gap = it.last_acked_seq - win_end;
			if (!gap[31]) begin
				g = (gain > dce_pkg::Q16_ONE) ? dce_pkg::Q16_ONE : gain;
				one = 64'd1 << FRAC_BITS;
				if (bytes_total == 32'd0) begin
					frac = 64'd0;
				end else begin
					frac = (64'(bytes_marked) << FRAC_BITS) / 64'(bytes_total);
					if (frac > one)
						frac = one;
					if (FRAC_BITS >= 16)
						frac = frac >> (FRAC_BITS - 16);
					else
						frac = frac << (16 - FRAC_BITS);
					if (frac > 64'(dce_pkg::Q16_ONE))
						frac = 64'(dce_pkg::Q16_ONE);
				end
				acc = 64'(alpha) * (64'(dce_pkg::Q16_ONE) - 64'(g)) + frac * 64'(g);
				acc = acc >> 16;
				alpha = (acc > 64'(dce_pkg::Q16_ONE)) ? dce_pkg::Q16_ONE : acc[16:0];
				win_end = it.next_tx_seq;
				bytes_total = 32'd0;
				bytes_marked = 32'd0;
				r.window_closed = 1'b1;
			end
		end
		r.alpha_q16 = alpha;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain = dce_pkg::GAIN_RESET;
			seg_bytes = dce_pkg::SEG_RESET;
			alpha = dce_pkg::Q16_ONE;
			bytes_total = 32'd0;
			bytes_marked = 32'd0;
			win_end = 32'd0;
			win_valid = 1'b0;
			awaited_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin : watch
			dce_pkg::result_t want;
			if (cfg_we) begin
				if (cfg_idx == dce_pkg::REG_GAIN)
					gain = cfg_data[16:0];
				else if (cfg_idx == dce_pkg::REG_SEG)
					seg_bytes = cfg_data[15:0];
			end
			// retire before accepting, so a stray result is never matched to a fresh item
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display({"%0t: expected no result,",
						" got alpha %0d closed %0d ssthresh %0d"},
						$time, result.alpha_q16, result.window_closed,
						result.ssthresh_bytes);
				end else begin
					want = awaited_results.pop_front();
					if (result !== want) begin
						mismatches++;
						$display({"%0t: expected alpha %0d closed %0d ssthresh %0d,",
							" got alpha %0d closed %0d ssthresh %0d"},
							$time, want.alpha_q16, want.window_closed,
							want.ssthresh_bytes, result.alpha_q16,
							result.window_closed, result.ssthresh_bytes);
					end
				end
			end
			if (push && !full)
				awaited_results.push_back(estimate(item));
			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: tb/dctcp_congestion_estimator_top_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict only; the checker beside the block does all prediction.
module dctcp_congestion_estimator_top_test;

	localparam int unsigned FRAC = 16;
	localparam int unsigned PHASE_ITEMS = 450;
	localparam int unsigned HOLD_CYCLES = 300;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  push = 1'b0;
	logic                                  full;
	dce_pkg::item_t                        item = '0;
	logic                                  pop = 1'b0;
	logic                                  empty;
	dce_pkg::result_t                      result;
	logic                                  cfg_we = 1'b0;
	logic [dce_pkg::CFG_IDX_W-1:0]         cfg_idx = '0;
	logic [dce_pkg::CFG_DATA_W-1:0]        cfg_data = '0;

	int mismatches;
	int outstanding;

	// idle odds in percent; sender side read only by the stimulus process
	int send_idle = 0;
	int recv_idle = 0;

	// long receiver hold-off, asked for by the stimulus, served by the receiver
	int hold_asks = 0;
	int hold_served = 0;
	int hold_left = 0;

	// running ack stream: acked edge, send edge, and the chance an item carries an echo
	logic [31:0] flow_acked;
	logic [31:0] flow_next;
	int          ece_pct;

	dctcp_congestion_estimator_top #(
		.FRAC_BITS(FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	dctcp_congestion_estimator_checker #(
		.FRAC_BITS(FRAC)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// generous ceiling; a healthy run is well under a tenth of this
	initial begin
		#6_000_000;
		$display("dctcp_congestion_estimator_top: mismatch");
		$finish;
	end

	// receiver: random pop, or a long hold so the command queue backs up into full
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else if (hold_asks != hold_served) begin
			hold_served <= hold_asks;
			hold_left <= HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// offers one item, with random gaps first; returns at the edge that takes it.
	// push is left high so back-to-back items need no second assignment in a step.
	task automatic offer(input dce_pkg::item_t x);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= x;
		do @(posedge clk); while (full);
	endtask

	// stop offering and wait for every awaited result, leaving the block idle
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// both registers in two consecutive writes, so the enable is only lowered once
	task automatic write_regs(input logic [16:0] g, input logic [16:0] s);
		cfg_we <= 1'b1;
		cfg_idx <= dce_pkg::REG_GAIN;
		cfg_data <= g;
		@(posedge clk);
		cfg_idx <= dce_pkg::REG_SEG;
		cfg_data <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic dce_pkg::item_t mk(input logic op, input logic [15:0] segs,
			input logic ece, input logic [31:0] acked, input logic [31:0] nxt,
			input logic [31:0] cwnd);
		dce_pkg::item_t x;
		x.op = op;
		x.segments_acked = segs;
		x.ece_received = ece;
		x.last_acked_seq = acked;
		x.next_tx_seq = nxt;
		x.cwnd_bytes = cwnd;
		return x;
	endfunction

	// Mostly a believable ack stream (acked edge creeping up, send edge ahead of it),
	// so windows open and close every few items; the rest is loss queries and junk.
	task automatic offer_random();
		dce_pkg::item_t x;
		int             kind;
		logic [31:0]    gap;
		kind = $urandom_range(99);
		x.segments_acked = $urandom_range(65535);
		x.ece_received = $urandom_range(1);
		x.last_acked_seq = $urandom;
		x.next_tx_seq = $urandom;
		x.cwnd_bytes = $urandom;
		if (kind < 12) begin
			x.op = dce_pkg::OP_LOSS;
		end else if (kind < 24) begin
			x.op = dce_pkg::OP_ACK;
		end else begin
			x.op = dce_pkg::OP_ACK;
			if ($urandom_range(9) != 0)
				x.segments_acked = $urandom_range(40);
			flow_acked = flow_acked + $urandom_range(60000);
			gap = flow_next - flow_acked;
			if (gap[31] || gap < 32'd2000)
				flow_next = flow_acked + $urandom_range(150000);
			else
				flow_next = flow_next + $urandom_range(30000);
			x.ece_received = ($urandom_range(99) < ece_pct);
			x.last_acked_seq = flow_acked;
			x.next_tx_seq = flow_next;
		end
		if ($urandom_range(19) == 0)
			ece_pct = $urandom_range(100);
		offer(x);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at reset settings (gain 1/16, 1448-byte segments, alpha 1.0).
		// Loss at alpha 1.0 halves the window; zero window gives zero.
		offer(mk(dce_pkg::OP_LOSS, 16'd0, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF));
		offer(mk(dce_pkg::OP_LOSS, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
		// first ack latches window end 5000; acked just short of it stays open
		offer(mk(dce_pkg::OP_ACK, 16'd10, 1'b1, 32'd100, 32'd5000, 32'd0));
		offer(mk(dce_pkg::OP_ACK, 16'd0, 1'b0, 32'd4999, 32'd9000, 32'd0));
		// exactly at window end: closes with a partial fraction
		offer(mk(dce_pkg::OP_ACK, 16'hFFFF, 1'b0, 32'd5000, 32'd9000, 32'd0));
		// empty window closes with fraction zero; new end just below the wrap
		offer(mk(dce_pkg::OP_ACK, 16'd0, 1'b1, 32'd9000, 32'hFFFF_FFF0, 32'd0));
		// half a sequence space away counts as behind
		offer(mk(dce_pkg::OP_ACK, 16'd3, 1'b1, 32'h7FFF_FFF0, 32'h0000_0010, 32'd0));
		// past the wrap counts as reached; fully marked window
		offer(mk(dce_pkg::OP_ACK, 16'd5, 1'b1, 32'h0000_0005, 32'h0000_0010, 32'd0));
		offer(mk(dce_pkg::OP_LOSS, 16'd0, 1'b0, 32'd0, 32'd0, 32'h8000_0001));

		// gain written above one (used as one), largest segment, top data bit set
		settle();
		write_regs(17'h1FFFF, 17'h1FFFF);
		// three full echoed acks saturate both counters
		repeat (3)
			offer(mk(dce_pkg::OP_ACK, 16'hFFFF, 1'b1, 32'h0000_000F, 32'h0000_0020, 32'd0));
		offer(mk(dce_pkg::OP_ACK, 16'hFFFF, 1'b0, 32'h0000_0010, 32'h0000_0020, 32'd0));
		// unmarked window at full gain drives alpha to zero; loss then returns cwnd
		offer(mk(dce_pkg::OP_ACK, 16'd1, 1'b0, 32'h0000_0020, 32'h0000_0030, 32'd0));
		offer(mk(dce_pkg::OP_LOSS, 16'd0, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF));

		// zero gain freezes alpha; zero segment size adds nothing
		settle();
		write_regs(17'd0, 17'd0);
		offer(mk(dce_pkg::OP_ACK, 16'hFFFF, 1'b1, 32'h0000_0030, 32'h0000_0040, 32'd0));
		offer(mk(dce_pkg::OP_LOSS, 16'd0, 1'b0, 32'd0, 32'd0, 32'h1234_5678));

		// gain exactly one, one-byte segments
		settle();
		write_regs(dce_pkg::Q16_ONE, 17'd1);
		offer(mk(dce_pkg::OP_ACK, 16'd7, 1'b1, 32'h0000_0040, 32'h0000_0050, 32'd0));
		offer(mk(dce_pkg::OP_LOSS, 16'd0, 1'b0, 32'd0, 32'd0, 32'hDEAD_BEEF));

		// Random phases: sender-light/receiver-heavy idling, then the reverse,
		// then none at all with a long receiver hold at the start.
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			case (ph)
				0: begin
					write_regs(17'($urandom_range(65536)), 17'($urandom_range(131071)));
					send_idle = 26;
					recv_idle <= 77;
				end
				1: begin
					write_regs(dce_pkg::Q16_ONE, 17'h0FFFF);
					send_idle = 77;
					recv_idle <= 26;
				end
				default: begin
					write_regs(17'd1, 17'd1);
					send_idle = 0;
					recv_idle <= 0;
					hold_asks <= hold_asks + 1;
				end
			endcase
			flow_acked = $urandom;
			flow_next = flow_acked + 32'd1000;
			ece_pct = $urandom_range(100);
			repeat (PHASE_ITEMS) offer_random();
		end

		settle();
		// a window-closing ack is the slowest path; give stray results time to show
		repeat (FRAC + 16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("dctcp_congestion_estimator_top: match");
		else
			$display("dctcp_congestion_estimator_top: mismatch");
		$finish;
	end

endmodule
